/* rtl/priority_message_slot_queue_assert.svh */
// Assertion macros for the priority message slot queue.
// Uses clk and rst_n from the including module's scope.
`ifndef PRIORITY_MESSAGE_SLOT_QUEUE_ASSERT_SVH
`define PRIORITY_MESSAGE_SLOT_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PMSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PMSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMSQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define PMSQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/pmsq_pkg.sv */
// Shared types and constants for the priority message slot queue.
// No dependencies.
`default_nettype none

package pmsq_pkg;

  localparam int PRIO_W  = 16;
  localparam int LEN_W   = 21;
  localparam int PAY_W   = 64;
  localparam int ORD_W   = 64;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  localparam logic [PRIO_W-1:0] PRIO_LIMIT = 16'd32768;
  localparam logic [LEN_W-1:0]  SIZE_LIMIT = 21'd1048576;

  localparam logic [COUNT_W-1:0] MAX_MESSAGES_RST = 5'd10;
  localparam logic [LEN_W-1:0]   MESSAGE_SIZE_RST = 21'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_SIZE = 1'd1;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_PRIO = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STAT_W-1:0] ST_SMALL    = 3'd5;

  // one stored message
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  payload;
    logic [ORD_W-1:0]  order;
  } entry_t;

  // running result handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [ORD_W-1:0]  order;
    logic              free_found;
  } scan_t;

  // captured input item
  typedef struct packed {
    logic              command;
    logic [PRIO_W-1:0] priority_req;
    logic [LEN_W-1:0]  message_length;
    logic [PAY_W-1:0]  payload_handle;
    logic [LEN_W-1:0]  receive_capacity;
  } item_t;

endpackage

`default_nettype wire

/* rtl/pmsq_if.sv */
// Channel interfaces: input items, result items and configuration writes.
// Depends on pmsq_pkg.
`default_nettype none

interface pmsq_in_if import pmsq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [PRIO_W-1:0] priority_req;
  logic [LEN_W-1:0]  message_length;
  logic [PAY_W-1:0]  payload_handle;
  logic [LEN_W-1:0]  receive_capacity;

  modport source (output valid, command, priority_req, message_length,
                  payload_handle, receive_capacity, input ready);
  modport sink   (input valid, command, priority_req, message_length,
                  payload_handle, receive_capacity, output ready);
endinterface

interface pmsq_out_if import pmsq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [PRIO_W-1:0]  out_priority;
  logic [LEN_W-1:0]   out_length;
  logic [PAY_W-1:0]   out_payload;
  logic [COUNT_W-1:0] current_count;

  modport source (output valid, status, out_priority, out_length, out_payload,
                  current_count, input ready);
  modport sink   (input valid, status, out_priority, out_length, out_payload,
                  current_count, output ready);
endinterface

interface pmsq_cfg_if import pmsq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

/* rtl/priority_message_slot_queue.sv */
// Priority message slot queue: a row of MAX_SLOTS message slots. A send
// stores priority, length and payload handle with a fresh sequence number in
// the lowest free slot among the first max_messages slots; a receive returns
// the highest-priority message, oldest first within a priority, and frees its
// slot. Each slot cell also holds one register stage of the selection chain:
// the best-so-far candidate and the first free slot move one cell per cycle,
// so a decision is ready once they have passed all MAX_SLOTS cells. A new
// item is taken only after the previous one has been decided; the result is
// registered when the chain has settled and the output register is free, and
// may wait there while the next item is taken in. Results
// are status, the received message (zero unless a receive succeeds) and the
// message count after the operation. Configuration (capacity, message size)
// is accepted in any cycle and only meant to change while the queue is idle.
// Depends on pmsq_pkg, pmsq_if, pmsq_cell and the assertion macro header.
`default_nettype none
`include "priority_message_slot_queue_assert.svh"

module priority_message_slot_queue import pmsq_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pmsq_cfg_if.sink   cfg_if,
  pmsq_in_if.sink    in_if,
  pmsq_out_if.source out_if
);

  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CWRAW = $clog2(MAX_SLOTS + 1);
  localparam int CAPW  = (CWRAW > COUNT_W) ? CWRAW : COUNT_W;
  localparam int SCNW  = $clog2(MAX_SLOTS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // ---------------- configuration registers ----------------
  logic [COUNT_W-1:0] max_messages_r;
  logic [LEN_W-1:0]   message_size_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_messages_r <= MAX_MESSAGES_RST;
      message_size_r <= MESSAGE_SIZE_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.wr_index)
        REG_MAX_MESSAGES: max_messages_r <= cfg_if.wr_data[COUNT_W-1:0];
        REG_MESSAGE_SIZE: message_size_r <= cfg_if.wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // capacity clamped to 1..MAX_SLOTS, size clamped to the byte limit
  logic [CAPW-1:0]  cap;
  logic [CAPW-1:0]  mm_ext;
  logic [LEN_W-1:0] size_use;

  assign mm_ext = CAPW'(max_messages_r);

  always_comb begin
    if (max_messages_r == '0) begin
      cap = CAPW'(1);
    end else if (mm_ext > CAPW'(MAX_SLOTS)) begin
      cap = CAPW'(MAX_SLOTS);
    end else begin
      cap = mm_ext;
    end
  end

  assign size_use = (message_size_r > SIZE_LIMIT) ? SIZE_LIMIT : message_size_r;

  // ---------------- control ----------------
  logic              state_r, state_nxt;
  logic [SCNW-1:0]   scan_cnt_r, scan_cnt_nxt;
  item_t             item_r;
  logic [ORD_W-1:0]  seq_r;
  logic [COUNT_W-1:0] count_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [PRIO_W-1:0] out_prio_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [PAY_W-1:0]  out_pay_r;
  logic [COUNT_W-1:0] out_count_r;

  logic in_acc;
  logic scan_done;
  logic commit;
  logic commit_send_ok;
  logic commit_recv_ok;
  logic [STAT_W-1:0] status_now;

  // ---------------- cell chain ----------------
  scan_t          scan_w   [MAX_SLOTS+1];
  logic [IW-1:0]  best_w   [MAX_SLOTS+1];
  logic [IW-1:0]  free_w   [MAX_SLOTS+1];
  logic [LEN_W-1:0] cell_len [MAX_SLOTS];
  logic [PAY_W-1:0] cell_pay [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] used_vec;
  entry_t         wr_entry;
  scan_t          scan_fin;
  logic [IW-1:0]  best_fin;
  logic [IW-1:0]  free_fin;

  assign scan_w[0] = '0;
  assign best_w[0] = '0;
  assign free_w[0] = '0;

  assign wr_entry.prio    = item_r.priority_req;
  assign wr_entry.len     = item_r.message_length;
  assign wr_entry.payload = item_r.payload_handle;
  assign wr_entry.order   = seq_r + ORD_W'(1);

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    logic cell_wr, cell_clr;
    assign cell_wr  = commit_send_ok && (free_fin == IW'(g));
    assign cell_clr = commit_recv_ok && (best_fin == IW'(g));

    pmsq_cell #(
      .CELL_ID (g),
      .IW      (IW),
      .CAPW    (CAPW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cap          (cap),
      .wr_en        (cell_wr),
      .clr_en       (cell_clr),
      .wr_data      (wr_entry),
      .scan_in      (scan_w[g]),
      .best_idx_in  (best_w[g]),
      .free_idx_in  (free_w[g]),
      .scan_out     (scan_w[g+1]),
      .best_idx_out (best_w[g+1]),
      .free_idx_out (free_w[g+1]),
      .used         (used_vec[g]),
      .len_q        (cell_len[g]),
      .payload_q    (cell_pay[g])
    );
  end

  assign scan_fin = scan_w[MAX_SLOTS];
  assign best_fin = best_w[MAX_SLOTS];
  assign free_fin = free_w[MAX_SLOTS];

  // ---------------- decision ----------------
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  // chain has had a full pass since the last slot change
  assign scan_done   = (state_r == ST_SCAN) && (scan_cnt_r == SCNW'(MAX_SLOTS));
  assign commit      = scan_done && (!out_valid_r || out_if.ready);

  always_comb begin
    if (item_r.command == CMD_SEND) begin
      if (item_r.priority_req > PRIO_LIMIT) begin
        status_now = ST_BAD_PRIO;
      end else if (item_r.message_length > size_use) begin
        status_now = ST_TOO_LONG;
      end else if (CAPW'(count_r) >= cap) begin
        status_now = ST_FULL;
      end else if (!scan_fin.free_found) begin
        status_now = ST_FULL;
      end else begin
        status_now = ST_OK;
      end
    end else begin
      if (item_r.receive_capacity < size_use) begin
        status_now = ST_SMALL;
      end else if (!scan_fin.found) begin
        status_now = ST_EMPTY;
      end else begin
        status_now = ST_OK;
      end
    end
  end

  assign commit_send_ok = commit && (item_r.command == CMD_SEND) && (status_now == ST_OK);
  assign commit_recv_ok = commit && (item_r.command == CMD_RECV) && (status_now == ST_OK);

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end else if (!scan_done) begin
          scan_cnt_nxt = scan_cnt_r + SCNW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      seq_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (commit_send_ok) begin
        seq_r   <= seq_r + ORD_W'(1);
        count_r <= count_r + COUNT_W'(1);
      end else if (commit_recv_ok && (count_r != '0)) begin
        count_r <= count_r - COUNT_W'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.command          <= in_if.command;
      item_r.priority_req     <= in_if.priority_req;
      item_r.message_length   <= in_if.message_length;
      item_r.payload_handle   <= in_if.payload_handle;
      item_r.receive_capacity <= in_if.receive_capacity;
    end
    if (commit) begin
      out_status_r <= status_now;
      if (commit_recv_ok) begin
        out_prio_r  <= scan_fin.prio;
        out_len_r   <= cell_len[best_fin];
        out_pay_r   <= cell_pay[best_fin];
        out_count_r <= (count_r != '0) ? (count_r - COUNT_W'(1)) : count_r;
      end else begin
        out_prio_r  <= '0;
        out_len_r   <= '0;
        out_pay_r   <= '0;
        out_count_r <= commit_send_ok ? (count_r + COUNT_W'(1)) : count_r;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.out_priority  = out_prio_r;
  assign out_if.out_length    = out_len_r;
  assign out_if.out_payload   = out_pay_r;
  assign out_if.current_count = out_count_r;

  // ---------------- assertions ----------------
  `PMSQ_ASSERT_IMPL(a_count_matches_used, 1'b1, $countones(used_vec) == int'(count_r), "count out of step with used slots")
  `PMSQ_ASSERT_IMPL(a_send_slot_free, commit_send_ok, !used_vec[free_fin], "send picked a used slot")
  `PMSQ_ASSERT_NEXT(a_recv_dec, commit_recv_ok, count_r == $past(count_r) - COUNT_W'(1), "receive did not drop count")
  `PMSQ_ASSERT_NEXT(a_seq_step, commit_send_ok, seq_r == $past(seq_r) + ORD_W'(1), "sequence did not advance on send")

endmodule

`default_nettype wire

/* rtl/pmsq_cell.sv */
// One message slot plus one stage of the selection chain.
// Depends on pmsq_pkg.
`default_nettype none

module pmsq_cell import pmsq_pkg::*; #(
  parameter int CELL_ID = 0,
  parameter int IW      = 4,
  parameter int CAPW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CAPW-1:0]  cap,
  input  wire logic             wr_en,
  input  wire logic             clr_en,
  input  wire entry_t           wr_data,
  input  wire scan_t            scan_in,
  input  wire logic [IW-1:0]    best_idx_in,
  input  wire logic [IW-1:0]    free_idx_in,
  output scan_t                 scan_out,
  output logic [IW-1:0]         best_idx_out,
  output logic [IW-1:0]         free_idx_out,
  output logic                  used,
  output logic [LEN_W-1:0]      len_q,
  output logic [PAY_W-1:0]      payload_q
);

  localparam logic [IW-1:0]   MY_IDX = IW'(CELL_ID);
  localparam logic [CAPW-1:0] MY_POS = CAPW'(CELL_ID);

  logic          used_r;
  entry_t        ent_r;
  scan_t         scan_r, scan_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          take_best, take_free;

  // higher priority wins, older sequence number breaks a tie
  assign take_best = used_r &&
                     (!scan_in.found || (ent_r.prio > scan_in.prio) ||
                      ((ent_r.prio == scan_in.prio) && (ent_r.order < scan_in.order)));
  assign take_free = !scan_in.free_found && !used_r && (MY_POS < cap);

  always_comb begin
    scan_nxt     = scan_in;
    best_idx_nxt = best_idx_in;
    free_idx_nxt = free_idx_in;
    if (take_best) begin
      scan_nxt.found = 1'b1;
      scan_nxt.prio  = ent_r.prio;
      scan_nxt.order = ent_r.order;
      best_idx_nxt   = MY_IDX;
    end
    if (take_free) begin
      scan_nxt.free_found = 1'b1;
      free_idx_nxt        = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (wr_en) begin
      used_r <= 1'b1;
    end else if (clr_en) begin
      used_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_data;
    end
    scan_r     <= scan_nxt;
    best_idx_r <= best_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign scan_out     = scan_r;
  assign best_idx_out = best_idx_r;
  assign free_idx_out = free_idx_r;
  assign used         = used_r;
  assign len_q        = ent_r.len;
  assign payload_q    = ent_r.payload;

endmodule

`default_nettype wire

/* test/tb_priority_message_slot_queue.sv */
// Testbench for priority_message_slot_queue: directed and random sends and receives
// are checked against a predictor of the slot table. Depends on pmsq_pkg, the
// pmsq_*_if interfaces and the RTL of the block.
module tb_priority_message_slot_queue import pmsq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS      = 16;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int LEN_MAX_FIELD  = 2097151;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 125;

  // One expected result item.
  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [PRIO_W-1:0]  prio;
    logic [LEN_W-1:0]   len;
    logic [PAY_W-1:0]   payload;
    logic [COUNT_W-1:0] count;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  pmsq_cfg_if cfg_if ();
  pmsq_in_if  in_if ();
  pmsq_out_if out_if ();

  priority_message_slot_queue #(.MAX_SLOTS(NUM_SLOTS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the slot table and the two registers.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cap_reg;
  logic [LEN_W-1:0]   size_reg;
  bit                 held_used    [NUM_SLOTS];
  logic [PRIO_W-1:0]  held_prio    [NUM_SLOTS];
  logic [LEN_W-1:0]   held_len     [NUM_SLOTS];
  logic [PAY_W-1:0]   held_payload [NUM_SLOTS];
  logic [ORD_W-1:0]   held_seq     [NUM_SLOTS];
  logic [ORD_W-1:0]   seq_num;
  int                 held_count;

  queue_reply_t pending_replies[$];  // results owed by the block, oldest first
  int           fail_count = 0;
  bit           idling_on  = 1'b0;   // random gaps on both channels when set

  // Capacity register: zero acts as one, anything past the table as the table.
  function automatic int cap_in_use();
    if (cap_reg == 0) return 1;
    if (cap_reg > NUM_SLOTS) return NUM_SLOTS;
    return int'(cap_reg);
  endfunction

  // Message size register saturates at the largest legal size.
  function automatic logic [LEN_W-1:0] size_in_use();
    return (size_reg > SIZE_LIMIT) ? SIZE_LIMIT : size_reg;
  endfunction

  // Applies one item to the slot table copy and returns the result it must give.
  function automatic queue_reply_t predict_queue_op(item_t it);
    queue_reply_t r;
    int cap;
    int free_slot;
    int best;
    r = '{default: '0};
    if (it.command == CMD_SEND) begin
      cap = cap_in_use();
      free_slot = -1;
      for (int i = 0; i < cap; i++)
        if (!held_used[i] && free_slot < 0) free_slot = i;
      // priority checked first, then length, then room
      if (it.priority_req > PRIO_LIMIT) r.status = ST_BAD_PRIO;
      else if (it.message_length > size_in_use()) r.status = ST_TOO_LONG;
      else if (held_count >= cap || free_slot < 0) r.status = ST_FULL;
      else begin
        seq_num = seq_num + 1;
        held_used[free_slot]    = 1'b1;
        held_prio[free_slot]    = it.priority_req;
        held_len[free_slot]     = it.message_length;
        held_payload[free_slot] = it.payload_handle;
        held_seq[free_slot]     = seq_num;
        held_count++;
        r.status = ST_OK;
      end
    end else begin
      best = -1;
      if (it.receive_capacity < size_in_use()) r.status = ST_SMALL;
      else begin
        // the whole table is searched, even past a lowered capacity
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (held_used[i] && (best < 0 || held_prio[i] > held_prio[best] ||
              (held_prio[i] == held_prio[best] && held_seq[i] < held_seq[best])))
            best = i;
        end
        if (best < 0) r.status = ST_EMPTY;
        else begin
          r.status  = ST_OK;
          r.prio    = held_prio[best];
          r.len     = held_len[best];
          r.payload = held_payload[best];
          held_used[best] = 1'b0;
          if (held_count > 0) held_count--;
        end
      end
    end
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders and random helpers
  // ---------------------------------------------------------------------------
  function automatic logic [PAY_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, some medium, a rare long one.
  function automatic int gap_len();
    int r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Unused fields of an item carry random bits as well.
  function automatic item_t make_send(int prio, int len, logic [PAY_W-1:0] pay);
    item_t it;
    it.command          = CMD_SEND;
    it.priority_req     = PRIO_W'(prio);
    it.message_length   = LEN_W'(len);
    it.payload_handle   = pay;
    it.receive_capacity = LEN_W'($urandom);
    return it;
  endfunction

  function automatic item_t make_recv(int buf_size);
    item_t it;
    it.command          = CMD_RECV;
    it.priority_req     = PRIO_W'($urandom);
    it.message_length   = LEN_W'($urandom);
    it.payload_handle   = rand_payload();
    it.receive_capacity = LEN_W'(buf_size);
    return it;
  endfunction

  // Valid priority, biased to a few low values so ties are common.
  function automatic int rand_prio();
    int r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 3);
    if (r < 7) return ($urandom_range(0, 1) != 0) ? int'(PRIO_LIMIT) : 0;
    return $urandom_range(0, int'(PRIO_LIMIT));
  endfunction

  // Mostly well-formed sends and receives; about one in ten is built to be rejected.
  function automatic item_t rand_item(int send_pct);
    int sz = int'(size_in_use());
    int len;
    int buf_size;
    if ($urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 2))
        0: return make_send($urandom_range(int'(PRIO_LIMIT) + 1, 65535),
                            $urandom_range(0, LEN_MAX_FIELD), rand_payload());
        1: return make_send(rand_prio(), $urandom_range(sz + 1, LEN_MAX_FIELD),
                            rand_payload());
        default: return make_recv((sz > 0) ? $urandom_range(0, sz - 1) : 0);
      endcase
    end
    if ($urandom_range(0, 99) < send_pct) begin
      len = ($urandom_range(0, 4) == 0) ? sz : $urandom_range(0, sz);
      return make_send(rand_prio(), len, rand_payload());
    end
    buf_size = ($urandom_range(0, 4) == 0) ? sz : $urandom_range(sz, LEN_MAX_FIELD);
    return make_recv(buf_size);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Everything is driven right after a rising edge with NBAs.
  // ---------------------------------------------------------------------------

  // Leaves valid high after the handshake so back-to-back items need no
  // second assignment in the same step; a gap in the next call, or settle, lowers it.
  task automatic send_item(item_t it);
    int gap = idling_on ? gap_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.command          <= it.command;
    in_if.priority_req     <= it.priority_req;
    in_if.message_length   <= it.message_length;
    in_if.payload_handle   <= it.payload_handle;
    in_if.receive_capacity <= it.receive_capacity;
    do @(posedge clk); while (!in_if.ready);
    pending_replies.push_back(predict_queue_op(it));
  endtask

  // Writes both registers in one burst; only called while the queue is idle.
  task automatic write_cfg(logic [CFG_DATA_W-1:0] cap_data,
                           logic [CFG_DATA_W-1:0] size_data);
    cfg_if.valid    <= 1'b1;
    cfg_if.wr_index <= REG_MAX_MESSAGES;
    cfg_if.wr_data  <= cap_data;
    do @(posedge clk); while (!cfg_if.ready);
    cap_reg = cap_data[COUNT_W-1:0];
    cfg_if.wr_index <= REG_MESSAGE_SIZE;
    cfg_if.wr_data  <= size_data;
    do @(posedge clk); while (!cfg_if.ready);
    size_reg = size_data[LEN_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  // Stop sending and wait for every owed result, plus a few cycles of margin.
  task automatic settle_queue();
    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  int ready_hold = 0;
  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_if.ready <= 1'b1;
      if (idling_on && $urandom_range(0, 3) == 0) ready_hold = gap_len();
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $error("result item with nothing owed: status %0d", out_if.status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", want.status, out_if.status);
        compare_field("out_priority", want.prio, out_if.out_priority);
        compare_field("out_length", want.len, out_if.out_length);
        compare_field("out_payload", want.payload, out_if.out_payload);
        compare_field("current_count", want.count, out_if.current_count);
      end
    end
  end

  // Watchdog: a long stretch with no handshake on any channel means a hang.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Error statuses at the reset settings (capacity 10, size 8192), including
  // the check order: buffer size before empty, priority before length.
  task automatic test_reset_errors();
    send_item(make_recv(8191));                                  // buffer small
    send_item(make_recv(LEN_MAX_FIELD));                         // empty
    send_item(make_send(int'(PRIO_LIMIT) + 1, 10, rand_payload()));
    send_item(make_send(65535, LEN_MAX_FIELD, rand_payload()));  // priority wins
    send_item(make_send(0, 8193, rand_payload()));               // one byte too long
  endtask

  // Fill to capacity with ties and extremes, overflow once, then drain and
  // see highest priority first, oldest first within a priority.
  task automatic test_priority_order();
    int prios[10] = '{5, 32768, 5, 0, 32768, 5, 0, 77, 32768, 1};
    int lens[10]  = '{0, 8192, 100, 1, 7, 8192, 0, 8000, 1, 2};
    for (int i = 0; i < 10; i++)
      send_item(make_send(prios[i], lens[i],
                          (i == 1 || i == 6) ? '1 : (i == 0 || i == 8) ? '0 : rand_payload()));
    send_item(make_send(3, 3, rand_payload()));  // full
    send_item(make_recv(8191));                  // size checked even when full
    for (int i = 0; i < 10; i++) send_item(make_recv(8192));
  endtask

  // Register extremes: capacity 0 / 31 / lowered below the held count,
  // message size 0 / 1 / saturated.
  task automatic test_config_extremes();
    settle_queue();
    write_cfg('0, 21'd1);                        // capacity acts as one
    send_item(make_send(9, 1, rand_payload()));
    send_item(make_send(9, 2, rand_payload()));  // too long
    send_item(make_send(9, 0, rand_payload()));  // full
    send_item(make_recv(0));                     // buffer small
    send_item(make_recv(1));
    send_item(make_recv(1));                     // empty

    settle_queue();
    write_cfg(21'd31, '0);                       // whole table, zero-length only
    send_item(make_send(3, 1, rand_payload()));
    for (int i = 0; i < NUM_SLOTS; i++) send_item(make_send(i % 4, 0, rand_payload()));
    send_item(make_send(2, 0, rand_payload()));  // full
    send_item(make_recv(0));
    send_item(make_recv(0));

    // capacity lowered under 14 held messages, size register past the limit
    settle_queue();
    write_cfg(21'd3, '1);
    send_item(make_send(100, int'(SIZE_LIMIT) + 1, rand_payload()));
    send_item(make_send(100, int'(SIZE_LIMIT), rand_payload()));   // full
    send_item(make_recv(int'(SIZE_LIMIT) - 1));
    for (int i = 0; i < 14; i++) begin
      send_item(make_recv(int'(SIZE_LIMIT)));
      send_item(make_send(rand_prio(), (i % 2 == 0) ? int'(SIZE_LIMIT) : 0,
                          rand_payload()));
    end

    settle_queue();
    write_cfg(21'd17, SIZE_LIMIT);
    for (int i = 0; i < 18; i++) send_item(make_recv(int'(SIZE_LIMIT)));
  endtask

  // Random settings per phase; some phases run without any idling.
  task automatic test_random_traffic();
    int c;
    int sz;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_queue();
      case ($urandom_range(0, 5))
        0: c = 0;
        1: c = 1;
        2: c = NUM_SLOTS;
        3: c = 31;
        default: c = $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 7))
        0: sz = 0;
        1: sz = 1;
        2: sz = int'(SIZE_LIMIT);
        3: sz = LEN_MAX_FIELD;
        4, 5: sz = $urandom_range(1, 16384);
        default: sz = $urandom_range(0, LEN_MAX_FIELD);
      endcase
      // upper data bits of the capacity write are random and must be ignored
      write_cfg(CFG_DATA_W'({$urandom, 5'(c)}), CFG_DATA_W'(sz));
      idling_on = (p % 4 != 3) && ($urandom_range(0, 4) != 0);
      begin
        int send_pct = $urandom_range(35, 70);
        for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(send_pct));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                  = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.wr_index        = REG_MAX_MESSAGES;
    cfg_if.wr_data         = '0;
    in_if.valid            = 1'b0;
    in_if.command          = CMD_SEND;
    in_if.priority_req     = '0;
    in_if.message_length   = '0;
    in_if.payload_handle   = '0;
    in_if.receive_capacity = '0;

    cap_reg    = MAX_MESSAGES_RST;
    size_reg   = MESSAGE_SIZE_RST;
    seq_num    = '0;
    held_count = 0;
    foreach (held_used[i]) held_used[i] = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idling_on = 1'b1;
    test_reset_errors();
    test_priority_order();
    idling_on = 1'b0;
    test_config_extremes();
    test_random_traffic();

    settle_queue();
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/pmsq_pkg.sv
rtl/pmsq_if.sv
rtl/pmsq_cell.sv
rtl/priority_message_slot_queue.sv
test/tb_priority_message_slot_queue.sv
